>>> rtl/core/ctdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctdc_pkg
// Types, character codes, glyph tables and line masks for the charlieplex
// text display controller.
// ----------------------------------------------------------------------------
package ctdc_pkg;

  typedef struct packed {
    logic       kind;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic [4:0] high_lines;
    logic [4:0] driven_lines;
  } out_item_t;

  typedef logic [3:0][7:0] store_t;

  typedef struct packed {
    store_t     store;
    logic [2:0] cursor;
  } disp_state_t;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_ESC     = 8'h1B;
  localparam logic [7:0] CH_FF      = 8'h0C;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PERIOD  = 8'h2E;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UC_A    = 8'h41;
  localparam logic [7:0] CH_UC_Z    = 8'h5A;
  localparam logic [7:0] CH_LC_A    = 8'h61;
  localparam logic [7:0] CH_LC_Z    = 8'h7A;

  localparam logic [2:0] NUM_SLOTS  = 3'd4;
  localparam logic [2:0] GLYPH_LIM  = 3'd3;

  localparam store_t BOOT_STORE = {8'h00, 8'h40, 8'h40, 8'h00};

  localparam logic [7:0] DP_BIT      = 8'h80;
  localparam logic [7:0] MINUS_BIT   = 8'h40;
  localparam logic [7:0] PERCENT_BIT = 8'h04;
  localparam logic [7:0] DOLLAR_BIT  = 8'h01;
  localparam logic [7:0] STAR_BIT    = 8'h02;

  localparam logic [7:0] DIGIT_PAT [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
  };

  localparam logic [7:0] LETTER_PAT [26] = '{
    8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71,
    8'h3D, 8'h76, 8'h30, 8'h0E, 8'h76, 8'h38,
    8'h37, 8'h54, 8'h5C, 8'h73, 8'h67, 8'h50,
    8'h6D, 8'h78, 8'h3E, 8'h1C, 8'h1C, 8'h36,
    8'h62, 8'h5B
  };

  localparam logic [4:0] LINE1 = 5'b00001;
  localparam logic [4:0] LINE2 = 5'b00010;
  localparam logic [4:0] LINE3 = 5'b00100;
  localparam logic [4:0] LINE4 = 5'b01000;
  localparam logic [4:0] LINE5 = 5'b10000;

  localparam logic [2:0] PH_LINE1 = 3'd0;
  localparam logic [2:0] PH_LINE2 = 3'd1;
  localparam logic [2:0] PH_LINE3 = 3'd2;
  localparam logic [2:0] PH_LINE4 = 3'd3;
  localparam logic [2:0] PH_LINE5 = 3'd4;

endpackage

>>> rtl/core/ctdc_char_dec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctdc_char_dec
// Next segment store and cursor for one received character.
// ----------------------------------------------------------------------------
module ctdc_char_dec (
  input  logic [7:0]           char_code_i,
  input  ctdc_pkg::disp_state_t cur_i,
  output ctdc_pkg::disp_state_t nxt_o
);

  logic [1:0] wr_slot;
  logic [1:0] dp_slot;
  logic [2:0] cursor_inc;
  logic       is_digit;
  logic       is_upper;
  logic       is_lower;
  logic [7:0] digit_off;
  logic [7:0] upper_off;
  logic [7:0] lower_off;
  logic [7:0] glyph;

  always_comb begin
    wr_slot    = cur_i.cursor[1:0];
    cursor_inc = cur_i.cursor + 3'd1;
    dp_slot    = (cur_i.cursor != 3'd0) ? 2'(cur_i.cursor - 3'd1) : 2'd0;

    is_digit = (char_code_i >= ctdc_pkg::CH_ZERO) && (char_code_i <= ctdc_pkg::CH_NINE);
    is_upper = (char_code_i >= ctdc_pkg::CH_UC_A) && (char_code_i <= ctdc_pkg::CH_UC_Z);
    is_lower = (char_code_i >= ctdc_pkg::CH_LC_A) && (char_code_i <= ctdc_pkg::CH_LC_Z);
    digit_off = char_code_i - ctdc_pkg::CH_ZERO;
    upper_off = char_code_i - ctdc_pkg::CH_UC_A;
    lower_off = char_code_i - ctdc_pkg::CH_LC_A;

    glyph = 8'h00;
    if (is_digit) begin
      glyph = ctdc_pkg::DIGIT_PAT[digit_off[3:0]];
    end else if (is_upper) begin
      glyph = ctdc_pkg::LETTER_PAT[upper_off[4:0]];
    end else if (is_lower) begin
      glyph = ctdc_pkg::LETTER_PAT[lower_off[4:0]];
    end

    nxt_o = cur_i;
    unique case (char_code_i) inside
      ctdc_pkg::CH_NUL: begin
      end
      ctdc_pkg::CH_ESC: begin
        nxt_o.store  = ctdc_pkg::BOOT_STORE;
        nxt_o.cursor = 3'd0;
      end
      ctdc_pkg::CH_FF: begin
        nxt_o.store  = '0;
        nxt_o.cursor = 3'd0;
      end
      ctdc_pkg::CH_LF, ctdc_pkg::CH_CR: begin
        nxt_o.cursor = 3'd0;
      end
      ctdc_pkg::CH_SPACE: begin
        if (cur_i.cursor < ctdc_pkg::NUM_SLOTS) begin
          nxt_o.store[wr_slot] = 8'h00;
          nxt_o.cursor         = cursor_inc;
        end
      end
      ctdc_pkg::CH_PERIOD: begin
        nxt_o.store[dp_slot] = cur_i.store[dp_slot] | ctdc_pkg::DP_BIT;
      end
      ctdc_pkg::CH_MINUS: begin
        nxt_o.store[0] = cur_i.store[0] | ctdc_pkg::MINUS_BIT;
      end
      ctdc_pkg::CH_PERCENT: begin
        nxt_o.store[3] = cur_i.store[3] | ctdc_pkg::PERCENT_BIT;
      end
      ctdc_pkg::CH_DOLLAR: begin
        nxt_o.store[3] = cur_i.store[3] | ctdc_pkg::DOLLAR_BIT;
      end
      ctdc_pkg::CH_STAR: begin
        nxt_o.store[3] = cur_i.store[3] | ctdc_pkg::STAR_BIT;
      end
      default: begin
        if ((is_digit || is_upper || is_lower) && (cur_i.cursor < ctdc_pkg::GLYPH_LIM)) begin
          nxt_o.store[wr_slot] = glyph;
          nxt_o.cursor         = cursor_inc;
        end
      end
    endcase
  end

endmodule

>>> rtl/core/ctdc_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctdc_scan
// Charlieplex line drive for one scan phase, and the index of the following phase.
// ----------------------------------------------------------------------------
module ctdc_scan (
  input  ctdc_pkg::store_t    store_i,
  input  logic [2:0]          phase_i,
  output ctdc_pkg::out_item_t drive_o,
  output logic [2:0]          phase_nxt_o
);

  always_comb begin
    drive_o = '0;
    unique case (phase_i)
      ctdc_pkg::PH_LINE1: begin
        drive_o.high_lines   = ctdc_pkg::LINE1;
        drive_o.driven_lines = ctdc_pkg::LINE1
                             | ({5{store_i[3][0]}} & ctdc_pkg::LINE5)
                             | ({5{store_i[3][1]}} & ctdc_pkg::LINE2)
                             | ({5{store_i[3][2]}} & ctdc_pkg::LINE3)
                             | ({5{store_i[3][3]}} & ctdc_pkg::LINE4);
      end
      ctdc_pkg::PH_LINE2: begin
        drive_o.high_lines   = ctdc_pkg::LINE2;
        drive_o.driven_lines = ctdc_pkg::LINE2
                             | ({5{store_i[0][1]}} & ctdc_pkg::LINE3)
                             | ({5{store_i[0][2]}} & ctdc_pkg::LINE4)
                             | ({5{store_i[2][4]}} & ctdc_pkg::LINE5)
                             | ({5{store_i[1][6]}} & ctdc_pkg::LINE1);
      end
      ctdc_pkg::PH_LINE3: begin
        drive_o.high_lines   = ctdc_pkg::LINE3;
        drive_o.driven_lines = ctdc_pkg::LINE3
                             | ({5{store_i[2][2]}} & ctdc_pkg::LINE5)
                             | ({5{store_i[1][0]}} & ctdc_pkg::LINE4)
                             | ({5{store_i[1][2]}} & ctdc_pkg::LINE2)
                             | ({5{store_i[1][5]}} & ctdc_pkg::LINE1);
      end
      ctdc_pkg::PH_LINE4: begin
        drive_o.high_lines   = ctdc_pkg::LINE4;
        drive_o.driven_lines = ctdc_pkg::LINE4
                             | ({5{store_i[2][0]}} & ctdc_pkg::LINE5)
                             | ({5{store_i[1][1]}} & ctdc_pkg::LINE3)
                             | ({5{store_i[1][3]}} & ctdc_pkg::LINE2)
                             | ({5{store_i[1][4]}} & ctdc_pkg::LINE1);
      end
      ctdc_pkg::PH_LINE5: begin
        drive_o.high_lines   = ctdc_pkg::LINE5;
        drive_o.driven_lines = ctdc_pkg::LINE5
                             | ({5{store_i[2][1]}} & ctdc_pkg::LINE4)
                             | ({5{store_i[2][3]}} & ctdc_pkg::LINE3)
                             | ({5{store_i[2][5]}} & ctdc_pkg::LINE2)
                             | ({5{store_i[2][6]}} & ctdc_pkg::LINE1);
      end
      default: begin
        drive_o = '0;
      end
    endcase
    phase_nxt_o = (phase_i >= ctdc_pkg::PH_LINE5) ? ctdc_pkg::PH_LINE1 : phase_i + 3'd1;
  end

endmodule

>>> rtl/core/charlieplex_text_display_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// charlieplex_text_display_controller
// Four-slot seven-segment text store edited by received characters; each
// scan tick yields the five-line charlieplex drive of the current phase.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_stall_o  | in_item_i  (kind, char_code)
//  out     | output    | out_valid_o / out_stall_i| out_item_o (high_lines, driven_lines)
//
//  An item is registered on accept and processed the next cycle unless it is a
//  tick held by a stalled result; one item per clock otherwise. A tick's result
//  appears in the cycle after processing. Characters give no result and never
//  wait on the output side. Reset loads the boot pattern, cursor 0 and the line
//  one phase. A tick waits in the input register while a prior result is stalled.
// ----------------------------------------------------------------------------
module charlieplex_text_display_controller (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ctdc_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ctdc_pkg::out_item_t out_item_o
);

  logic                  in_vld_q, in_vld_d;
  ctdc_pkg::in_item_t    in_q, in_d;
  logic                  out_vld_q, out_vld_d;
  ctdc_pkg::out_item_t   out_q, out_d;
  ctdc_pkg::disp_state_t st_q, st_d;
  logic [2:0]            phase_q, phase_d;

  ctdc_pkg::disp_state_t char_nxt;
  ctdc_pkg::out_item_t   scan_drive;
  logic [2:0]            scan_phase_nxt;
  logic                  is_tick;
  logic                  adv;
  logic                  accept;

  ctdc_char_dec u_char_dec (
    .char_code_i (in_q.char_code),
    .cur_i       (st_q),
    .nxt_o       (char_nxt)
  );

  ctdc_scan u_scan (
    .store_i     (st_q.store),
    .phase_i     (phase_q),
    .drive_o     (scan_drive),
    .phase_nxt_o (scan_phase_nxt)
  );

  always_comb begin
    is_tick    = (in_q.kind == ctdc_pkg::KIND_TICK);
    adv        = in_vld_q && (!is_tick || !out_vld_q || !out_stall_i);
    in_stall_o = in_vld_q && !adv;
    accept     = in_valid_i && !in_stall_o;

    in_vld_d = accept || (in_vld_q && !adv);
    in_d     = accept ? in_item_i : in_q;

    st_d    = st_q;
    phase_d = phase_q;
    out_d   = out_q;
    out_vld_d = out_vld_q && out_stall_i;
    if (adv) begin
      if (is_tick) begin
        phase_d   = scan_phase_nxt;
        out_d     = scan_drive;
        out_vld_d = 1'b1;
      end else begin
        st_d = char_nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      st_q      <= '{store: ctdc_pkg::BOOT_STORE, cursor: 3'd0};
      phase_q   <= ctdc_pkg::PH_LINE1;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      st_q      <= st_d;
      phase_q   <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q  <= in_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

`ifndef SYNTHESIS
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.cursor <= ctdc_pkg::NUM_SLOTS)
    else $error("cursor beyond slot count");

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= ctdc_pkg::PH_LINE5)
    else $error("scan phase out of range");

  a_high_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> $onehot(out_q.high_lines))
    else $error("result without exactly one high line");

  a_high_driven: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> ((out_q.high_lines & ~out_q.driven_lines) == 5'd0))
    else $error("high line not among driven lines");

  a_tick_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && is_tick) |=> out_vld_q)
    else $error("processed tick left no result");
`endif

endmodule
